[hw/rtl/cluster_hadron_fraction_accumulator_unit_assert.svh]
// Assertion macros shared by the accumulator modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CLUSTER_HADRON_FRACTION_ACCUMULATOR_UNIT_ASSERT_SVH
`define CLUSTER_HADRON_FRACTION_ACCUMULATOR_UNIT_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define CHFA_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// A condition that forces another in the same cycle.
`define CHFA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// A condition that forces another in the following cycle.
`define CHFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[hw/rtl/chfa_pkg.sv]
// Types and constants for the cluster hadron fraction accumulator.
// Used by every module of the block; depends on nothing.
package chfa_pkg;

  localparam int CFG_W     = 16;
  localparam int ENERGY_W  = 18;
  localparam int WEIGHT_W  = 17;
  localparam int SUM_W     = 25;
  localparam int CNT_W     = 23;
  localparam int INT_W     = 18;
  localparam int FRAC_BITS = 16;
  localparam int DIV_W     = SUM_W + FRAC_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] HAD_THR_RESET = 16'd30;
  localparam logic [CFG_W-1:0] INT_THR_RESET = 16'd328;
  localparam logic [CFG_W-1:0] SPLIT_RESET   = 16'd6000;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 25'sh0FFFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 25'sh1000000;
  localparam logic [CNT_W-1:0]        CNT_MAX = 23'h7FFFFF;

  localparam logic [INT_W-1:0] INT_POS_MAG = 18'd131071;
  localparam logic [INT_W-1:0] INT_NEG_MAG = 18'd131072;
  localparam logic [INT_W-1:0] INT_MAX     = 18'h1FFFF;
  localparam logic [INT_W-1:0] INT_MIN     = 18'h20000;

  typedef enum logic [1:0] {
    KIND_PHOTON_HADRON = 2'd0,
    KIND_BG_PHOTON     = 2'd1,
    KIND_POOR_CHI2     = 2'd2,
    KIND_DIODE         = 2'd3
  } fit_kind_t;

  typedef enum logic [1:0] {
    CFG_HAD_THR = 2'd0,
    CFG_INT_THR = 2'd1,
    CFG_SPLIT   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] had_thr;
    logic [CFG_W-1:0] int_thr;
    logic [CFG_W-1:0] split;
  } cfg_t;

  typedef struct packed {
    logic                    has_psd;
    logic signed [SUM_W-1:0] total_sum;
    logic signed [SUM_W-1:0] hadron_sum;
    logic [CNT_W-1:0]        hit_count;
  } clus_rec_t;

endpackage

[hw/rtl/chfa_front.sv]
// Front end: accepts hits, classifies them and keeps the running cluster sums.
// Pushes one finished cluster record per last hit; depends on chfa_pkg.
module chfa_front #(
  parameter int MAX_HITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_fit_valid,
  input  logic [1:0]                          in_fit_kind,
  input  logic signed [chfa_pkg::ENERGY_W-1:0] in_total_energy,
  input  logic signed [chfa_pkg::ENERGY_W-1:0] in_hadron_energy,
  input  logic [chfa_pkg::WEIGHT_W-1:0]       in_hit_weight,
  input  logic                                in_last_hit,
  input  chfa_pkg::cfg_t                      cfg,
  output logic                                push_valid,
  input  logic                                push_ready,
  output chfa_pkg::clus_rec_t                 push_rec
);
  import chfa_pkg::*;

  localparam int HC_W = $clog2(MAX_HITS + 1);

  logic [HC_W-1:0]             hit_cnt_r;
  logic                        p_vld_r;
  logic                        p_acc_r;
  logic                        p_had_r;
  logic                        p_last_r;
  logic signed [ENERGY_W-1:0]  p_tot_r;
  logic signed [ENERGY_W-1:0]  p_hadE_r;
  logic [WEIGHT_W-1:0]         p_w_r;

  logic signed [SUM_W-1:0]     tsum_r, tsum_nxt;
  logic signed [SUM_W-1:0]     hsum_r, hsum_nxt;
  logic [CNT_W-1:0]            csum_r, csum_nxt;
  logic [CNT_W-1:0]            wsum_r, wsum_nxt;

  logic                        under_limit;
  logic                        kind_ok;
  logic                        low_energy;
  logic                        had_low;
  logic                        had_high;
  logic                        hadronic;
  logic signed [ENERGY_W+FRAC_BITS:0] prod;
  logic signed [ENERGY_W+FRAC_BITS:0] had_sh;
  logic                        consume;

  function automatic logic signed [SUM_W-1:0] sat_add_s(
    input logic signed [SUM_W-1:0]    a,
    input logic signed [ENERGY_W-1:0] b
  );
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W + 1 - ENERGY_W){b[ENERGY_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add_u(
    input logic [CNT_W-1:0]    a,
    input logic [WEIGHT_W-1:0] b
  );
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W + 1 - WEIGHT_W){1'b0}}, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  assign under_limit = hit_cnt_r < HC_W'(MAX_HITS);
  assign kind_ok = (in_fit_kind != KIND_POOR_CHI2) && (in_fit_kind != KIND_DIODE);

  assign low_energy = $signed({in_total_energy[ENERGY_W-1], in_total_energy}) <
                      $signed({{(ENERGY_W + 1 - CFG_W){1'b0}}, cfg.split});
  assign had_low    = $signed({in_hadron_energy[ENERGY_W-1], in_hadron_energy}) >
                      $signed({{(ENERGY_W + 1 - CFG_W){1'b0}}, cfg.had_thr});
  assign prod       = $signed({1'b0, cfg.int_thr}) * in_total_energy;
  assign had_sh     = $signed({in_hadron_energy[ENERGY_W-1], in_hadron_energy,
                               {FRAC_BITS{1'b0}}});
  assign had_high   = had_sh > prod;
  assign hadronic   = low_energy ? had_low : had_high;

  assign consume  = p_vld_r && (!p_last_r || push_ready);
  assign in_ready = !p_vld_r || consume;

  always_comb begin
    tsum_nxt = tsum_r;
    hsum_nxt = hsum_r;
    csum_nxt = csum_r;
    wsum_nxt = wsum_r;
    if (p_acc_r) begin
      tsum_nxt = sat_add_s(tsum_r, p_tot_r);
      hsum_nxt = sat_add_s(hsum_r, p_hadE_r);
      wsum_nxt = sat_add_u(wsum_r, p_w_r);
      if (p_had_r) begin
        csum_nxt = sat_add_u(csum_r, p_w_r);
      end
    end
  end

  assign push_valid          = p_vld_r && p_last_r;
  assign push_rec.has_psd    = wsum_nxt != '0;
  assign push_rec.total_sum  = tsum_nxt;
  assign push_rec.hadron_sum = hsum_nxt;
  assign push_rec.hit_count  = csum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r <= '0;
      p_vld_r   <= 1'b0;
      tsum_r    <= '0;
      hsum_r    <= '0;
      csum_r    <= '0;
      wsum_r    <= '0;
    end else begin
      if (consume) begin
        if (p_last_r) begin
          tsum_r <= '0;
          hsum_r <= '0;
          csum_r <= '0;
          wsum_r <= '0;
        end else begin
          tsum_r <= tsum_nxt;
          hsum_r <= hsum_nxt;
          csum_r <= csum_nxt;
          wsum_r <= wsum_nxt;
        end
      end
      if (in_ready) begin
        p_vld_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        if (in_last_hit) begin
          hit_cnt_r <= '0;
        end else if (under_limit) begin
          hit_cnt_r <= hit_cnt_r + HC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_acc_r  <= under_limit && in_fit_valid && kind_ok;
      p_had_r  <= hadronic;
      p_last_r <= in_last_hit;
      p_tot_r  <= in_total_energy;
      p_hadE_r <= in_hadron_energy;
      p_w_r    <= in_hit_weight;
    end
  end

endmodule

[hw/rtl/chfa_queue.sv]
// Short queue of finished cluster records between the front and back ends.
// Register-based, QUEUE_DEPTH entries; depends on chfa_pkg and the assertion header.
`include "cluster_hadron_fraction_accumulator_unit_assert.svh"

module chfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  chfa_pkg::clus_rec_t push_rec,
  output logic                pop_valid,
  input  logic                pop_ready,
  output chfa_pkg::clus_rec_t pop_rec
);
  import chfa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  clus_rec_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;
  logic               push;
  logic               pop;

  assign push_ready = count_r != CNT_QW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  `CHFA_ASSERT_HOLDS(a_count_bound, count_r <= CNT_QW'(QUEUE_DEPTH))
  `CHFA_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + CNT_QW'(1))
  `CHFA_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_r == $past(count_r) - CNT_QW'(1))

endmodule

[hw/rtl/chfa_back.sv]
// Back end: takes a cluster record, divides the hadron sum by the total sum
// bit-serially if weighted and nonzero; output is registered; uses chfa_pkg.
`include "cluster_hadron_fraction_accumulator_unit_assert.svh"

module chfa_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rec_valid,
  output logic                             rec_ready,
  input  chfa_pkg::clus_rec_t              rec,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_has_psd,
  output logic                             out_intensity_set,
  output logic signed [chfa_pkg::INT_W-1:0] out_hadron_intensity,
  output logic [chfa_pkg::CNT_W-1:0]       out_hadron_hit_count
);
  import chfa_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t             state_r;
  clus_rec_t          rec_r;
  logic [SUM_W-1:0]   rem_r;
  logic [DIV_W-1:0]   dvd_r;
  logic [SUM_W-1:0]   dvs_r;
  logic [INT_W-1:0]   quo_r;
  logic               ovf_r;
  logic               neg_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  logic               out_has_psd_r;
  logic               out_set_r;
  logic [INT_W-1:0]   out_int_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic [SUM_W-1:0]   had_mag;
  logic [SUM_W-1:0]   tot_mag;
  logic [SUM_W:0]     rem_sh;
  logic               ge;
  logic               set;
  logic [INT_W-1:0]   int_sat;

  assign had_mag = rec.hadron_sum[SUM_W-1] ? SUM_W'(-rec.hadron_sum) : rec.hadron_sum;
  assign tot_mag = rec.total_sum[SUM_W-1] ? SUM_W'(-rec.total_sum) : rec.total_sum;

  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  assign set = rec_r.has_psd && (rec_r.total_sum != '0);

  always_comb begin
    if (!neg_r) begin
      int_sat = (ovf_r || quo_r > INT_POS_MAG) ? INT_MAX : quo_r;
    end else begin
      int_sat = (ovf_r || quo_r > INT_NEG_MAG) ? INT_MIN : INT_W'(-quo_r);
    end
  end

  assign rec_ready            = state_r == ST_IDLE;
  assign out_valid            = out_valid_r;
  assign out_has_psd          = out_has_psd_r;
  assign out_intensity_set    = out_set_r;
  assign out_hadron_intensity = out_int_r;
  assign out_hadron_hit_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (rec_valid) begin
            rec_r  <= rec;
            dvd_r  <= {had_mag, {FRAC_BITS{1'b0}}};
            dvs_r  <= tot_mag;
            rem_r  <= '0;
            quo_r  <= '0;
            ovf_r  <= 1'b0;
            neg_r  <= rec.hadron_sum[SUM_W-1] ^ rec.total_sum[SUM_W-1];
            step_r <= '0;
            state_r <= (rec.has_psd && rec.total_sum != '0) ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          rem_r  <= ge ? SUM_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SUM_W-1:0];
          dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
          quo_r  <= {quo_r[INT_W-2:0], ge};
          ovf_r  <= ovf_r | quo_r[INT_W-1];
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_W - 1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_has_psd_r <= rec_r.has_psd;
            out_set_r     <= set;
            out_int_r     <= set ? int_sat : '0;
            out_cnt_r     <= rec_r.has_psd ? rec_r.hit_count : '0;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `CHFA_ASSERT_IMPLIES(a_div_needs_total, state_r == ST_DIV,
                       rec_r.has_psd && rec_r.total_sum != '0)
  `CHFA_ASSERT_IMPLIES(a_step_bound, state_r == ST_DIV, step_r < STEP_W'(DIV_W))
  `CHFA_ASSERT_IMPLIES(a_set_needs_psd, out_valid_r && out_set_r, out_has_psd_r)

endmodule

[hw/rtl/cluster_hadron_fraction_accumulator_unit.sv]
// Top level of the cluster hadron fraction accumulator: configuration
// registers, front end, record queue and divider back end; uses chfa_pkg.
//
//   Channel  Direction  Beat contents
//   in_      input      one crystal hit of a cluster
//   out_     output     one cluster result, sent on the last hit
//   cfg_     input      register index and 16-bit write data
//
// The front end takes one hit per cycle unless stalled and registers it before
// adding it to the sums. A cluster result leaves the back end without passing
// the divider when there is no waveform weight or the total sum is zero, otherwise
// after the 41-step serial divider. Two finished clusters can wait in the queue;
// the input stalls only on a last hit while the queue is full.
// Reset is synchronous and clears control state and the sums; no clearing pass.
module cluster_hadron_fraction_accumulator_unit #(
  parameter int MAX_HITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_fit_valid,
  input  logic [1:0]                           in_fit_kind,
  input  logic signed [chfa_pkg::ENERGY_W-1:0] in_total_energy,
  input  logic signed [chfa_pkg::ENERGY_W-1:0] in_hadron_energy,
  input  logic [chfa_pkg::WEIGHT_W-1:0]        in_hit_weight,
  input  logic                                 in_last_hit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_has_psd,
  output logic                                 out_intensity_set,
  output logic signed [chfa_pkg::INT_W-1:0]    out_hadron_intensity,
  output logic [chfa_pkg::CNT_W-1:0]           out_hadron_hit_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [chfa_pkg::CFG_W-1:0]           cfg_data
);
  import chfa_pkg::*;

  cfg_t      cfg_r;
  logic      push_valid;
  logic      push_ready;
  clus_rec_t push_rec;
  logic      pop_valid;
  logic      pop_ready;
  clus_rec_t pop_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.had_thr <= HAD_THR_RESET;
      cfg_r.int_thr <= INT_THR_RESET;
      cfg_r.split   <= SPLIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HAD_THR: cfg_r.had_thr <= cfg_data;
        CFG_INT_THR: cfg_r.int_thr <= cfg_data;
        CFG_SPLIT:   cfg_r.split   <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  chfa_front #(
    .MAX_HITS (MAX_HITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_fit_valid     (in_fit_valid),
    .in_fit_kind      (in_fit_kind),
    .in_total_energy  (in_total_energy),
    .in_hadron_energy (in_hadron_energy),
    .in_hit_weight    (in_hit_weight),
    .in_last_hit      (in_last_hit),
    .cfg              (cfg_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_rec         (push_rec)
  );

  chfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  chfa_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .rec_valid            (pop_valid),
    .rec_ready            (pop_ready),
    .rec                  (pop_rec),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_has_psd          (out_has_psd),
    .out_intensity_set    (out_intensity_set),
    .out_hadron_intensity (out_hadron_intensity),
    .out_hadron_hit_count (out_hadron_hit_count)
  );

endmodule

[tb/cluster_hadron_fraction_accumulator_unit_test.sv]
// Self-checking bench for cluster_hadron_fraction_accumulator_unit, built on chfa_pkg.
// A queue-fed driver offers crystal hits, a bit-accurate predictor scores every cluster
// result beat, and configuration is rewritten between phases while the block is idle.
module cluster_hadron_fraction_accumulator_unit_test;
  import chfa_pkg::*;

  localparam int MAX_HITS      = 64;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_IDLE      = 16;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam longint SUM_HI = 64'sd16777215;
  localparam longint SUM_LO = -64'sd16777216;
  localparam longint INT_HI = 64'sd131071;
  localparam longint INT_LO = -64'sd131072;

  typedef struct {
    logic                       fit_valid;
    fit_kind_t                  fit_kind;
    logic signed [ENERGY_W-1:0] total_energy;
    logic signed [ENERGY_W-1:0] hadron_energy;
    logic [WEIGHT_W-1:0]        hit_weight;
    logic                       last_hit;
    int                         gap;
    bit                         drain;
  } hit_beat_t;

  typedef struct {
    logic                    has_psd;
    logic                    intensity_set;
    logic signed [INT_W-1:0] hadron_intensity;
    logic [CNT_W-1:0]        hadron_hit_count;
  } cluster_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_fit_valid = 1'b0;
  logic [1:0]                 in_fit_kind = '0;
  logic signed [ENERGY_W-1:0] in_total_energy = '0;
  logic signed [ENERGY_W-1:0] in_hadron_energy = '0;
  logic [WEIGHT_W-1:0]        in_hit_weight = '0;
  logic                       in_last_hit = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_has_psd;
  logic                       out_intensity_set;
  logic signed [INT_W-1:0]    out_hadron_intensity;
  logic [CNT_W-1:0]           out_hadron_hit_count;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  cluster_hadron_fraction_accumulator_unit #(
    .MAX_HITS(MAX_HITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_fit_valid(in_fit_valid),
    .in_fit_kind(in_fit_kind),
    .in_total_energy(in_total_energy),
    .in_hadron_energy(in_hadron_energy),
    .in_hit_weight(in_hit_weight),
    .in_last_hit(in_last_hit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_has_psd(out_has_psd),
    .out_intensity_set(out_intensity_set),
    .out_hadron_intensity(out_hadron_intensity),
    .out_hadron_hit_count(out_hadron_hit_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [CFG_W-1:0]        had_thr_reg = HAD_THR_RESET;
  logic [CFG_W-1:0]        int_thr_reg = INT_THR_RESET;
  logic [CFG_W-1:0]        split_reg = SPLIT_RESET;
  logic signed [SUM_W-1:0] total_acc = '0;
  logic signed [SUM_W-1:0] hadron_acc = '0;
  logic [CNT_W-1:0]        hadron_weight_acc = '0;
  logic [CNT_W-1:0]        psd_weight_acc = '0;
  int                      hits_in_cluster = 0;

  hit_beat_t       hit_queue[$];
  cluster_result_t due_results[$];
  hit_beat_t       cur_hit = '{1'b0, KIND_PHOTON_HADRON, '0, '0, '0, 1'b0, 0, 1'b0};
  bit              offering = 1'b0;
  int              gap_left = 0;
  int              clusters_issued = 0;
  int              clusters_sent = 0;
  int              clusters_seen = 0;
  int              hits_accepted = 0;
  int              hits_queued = 0;
  bit              result_staged = 1'b0;
  cluster_result_t staged_result;
  bit              quiet_tx = 1'b0;
  bit              quiet_rx = 1'b0;
  int              stall_left = 0;
  int              mismatches = 0;
  bit              hold_armed = 1'b0;
  bit              hold_done = 1'b0;
  int              hold_left = 0;
  int              cycles = 0;

  function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
    longint c;
    c = v;
    if (c > SUM_HI) c = SUM_HI;
    if (c < SUM_LO) c = SUM_LO;
    return c[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] add_weight(input logic [CNT_W-1:0] acc,
                                                  input logic [WEIGHT_W-1:0] w);
    longint s;
    s = acc;
    s = s + w;
    if (s > CNT_MAX) s = CNT_MAX;
    return s[CNT_W-1:0];
  endfunction

  task automatic accumulate_hit(input hit_beat_t h, output bit emits,
                                output cluster_result_t r);
    longint tot, had, thr_e, thr_i, split_e, acc, q;
    bit hadronic;
    tot = h.total_energy;
    had = h.hadron_energy;
    thr_e = had_thr_reg;
    thr_i = int_thr_reg;
    split_e = split_reg;
    emits = 1'b0;
    r = '{1'b0, 1'b0, '0, '0};
    if (hits_in_cluster < MAX_HITS) begin
      hits_in_cluster++;
      if (h.fit_valid && h.fit_kind != KIND_POOR_CHI2 && h.fit_kind != KIND_DIODE) begin
        acc = total_acc;
        total_acc = clamp_sum(acc + tot);
        acc = hadron_acc;
        hadron_acc = clamp_sum(acc + had);
        if (tot < split_e) begin
          hadronic = had > thr_e;
        end else begin
          hadronic = had * 64'sd65536 > thr_i * tot;
        end
        if (hadronic) hadron_weight_acc = add_weight(hadron_weight_acc, h.hit_weight);
        psd_weight_acc = add_weight(psd_weight_acc, h.hit_weight);
      end
    end
    if (h.last_hit) begin
      emits = 1'b1;
      if (psd_weight_acc != 0) begin
        r.has_psd = 1'b1;
        if (total_acc != 0) begin
          acc = hadron_acc;
          tot = total_acc;
          q = (acc * 64'sd65536) / tot;
          if (q > INT_HI) q = INT_HI;
          if (q < INT_LO) q = INT_LO;
          r.intensity_set = 1'b1;
          r.hadron_intensity = q[INT_W-1:0];
        end
        r.hadron_hit_count = hadron_weight_acc;
      end
      total_acc = '0;
      hadron_acc = '0;
      hadron_weight_acc = '0;
      psd_weight_acc = '0;
      hits_in_cluster = 0;
    end
  endtask

  always @(posedge clk) begin : drive_hits
    bit emits;
    cluster_result_t res;
    emits = 1'b0;
    res = '{1'b0, 1'b0, '0, '0};
    if (!rst_n) begin
      in_valid <= 1'b0;
      result_staged <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_hit(cur_hit, emits, res);
        hits_accepted <= hits_accepted + 1;
        offering = 1'b0;
        gap_left = cur_hit.gap;
        if (emits) clusters_issued++;
      end
      result_staged <= emits;
      staged_result <= res;
      clusters_sent <= clusters_issued;
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (hit_queue.size() > 0) begin
          if (hit_queue[0].drain) begin
            if (clusters_issued == clusters_seen) void'(hit_queue.pop_front());
          end else begin
            cur_hit = hit_queue.pop_front();
            offering = 1'b1;
          end
        end
      end
      in_valid <= offering;
      in_fit_valid <= cur_hit.fit_valid;
      in_fit_kind <= cur_hit.fit_kind;
      in_total_energy <= cur_hit.total_energy;
      in_hadron_energy <= cur_hit.hadron_energy;
      in_hit_weight <= cur_hit.hit_weight;
      in_last_hit <= cur_hit.last_hit;
    end
  end

  always @(posedge clk) begin : score_results
    cluster_result_t want;
    cluster_result_t got;
    got = '{out_has_psd, out_intensity_set, out_hadron_intensity, out_hadron_hit_count};
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_staged) due_results.push_back(staged_result);
      if (out_valid && out_ready) begin
        clusters_seen <= clusters_seen + 1;
        if (due_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result beat: psd=%0b set=%0b intensity=%0d count=%0d",
                     got.has_psd, got.intensity_set, got.hadron_intensity,
                     got.hadron_hit_count);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.has_psd !== want.has_psd || got.intensity_set !== want.intensity_set ||
              got.hadron_intensity !== want.hadron_intensity ||
              got.hadron_hit_count !== want.hadron_hit_count) begin
            if (mismatches < REPORT_LIMIT)
              $display("cluster %0d: expected psd=%0b set=%0b intensity=%0d count=%0d, %s",
                       clusters_seen, want.has_psd, want.intensity_set,
                       want.hadron_intensity, want.hadron_hit_count,
                       $sformatf("got psd=%0b set=%0b intensity=%0d count=%0d",
                                 got.has_psd, got.intensity_set, got.hadron_intensity,
                                 got.hadron_hit_count));
            mismatches++;
          end
        end
        if ($urandom_range(0, 7) == 0) quiet_rx = !quiet_rx;
        stall_left = quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cluster_hadron_fraction_accumulator_unit_test failed");
      $finish;
    end
  end

  task automatic push_hit(input hit_beat_t h, input bit rush);
    h.gap = (rush || quiet_tx) ? 0 : $urandom_range(0, MAX_IDLE);
    h.drain = 1'b0;
    hit_queue.push_back(h);
    hits_queued++;
  endtask

  task automatic add_hit(input logic v, input fit_kind_t kind, input int tot, input int had,
                         input int w, input logic last);
    hit_beat_t h;
    h.fit_valid = v;
    h.fit_kind = kind;
    h.total_energy = ENERGY_W'(tot);
    h.hadron_energy = ENERGY_W'(had);
    h.hit_weight = WEIGHT_W'(w);
    h.last_hit = last;
    push_hit(h, 1'b0);
  endtask

  function automatic hit_beat_t random_hit(input bit last, input bit broken);
    hit_beat_t h;
    longint t, p;
    int sel;
    h.fit_valid = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 9);
    if (sel < 4) h.fit_kind = KIND_PHOTON_HADRON;
    else if (sel < 8) h.fit_kind = KIND_BG_PHOTON;
    else if (sel == 8) h.fit_kind = KIND_POOR_CHI2;
    else h.fit_kind = KIND_DIODE;
    if (broken && h.fit_valid && sel < 8) h.fit_kind = sel[0] ? KIND_POOR_CHI2 : KIND_DIODE;
    case ($urandom_range(0, 3))
      0: h.total_energy = ENERGY_W'($urandom);
      1: h.total_energy = ENERGY_W'(int'(split_reg) + int'($urandom_range(0, 8)) - 4);
      2: h.total_energy = ENERGY_W'(int'($urandom_range(0, 2000)) - 1000);
      default: h.total_energy = ENERGY_W'($urandom_range(0, 40000));
    endcase
    t = h.total_energy;
    case ($urandom_range(0, 3))
      0: h.hadron_energy = ENERGY_W'($urandom);
      1: h.hadron_energy = ENERGY_W'(int'(had_thr_reg) + int'($urandom_range(0, 6)) - 3);
      2: begin
        p = (longint'(int_thr_reg) * t) >>> 16;
        h.hadron_energy = ENERGY_W'(p + int'($urandom_range(0, 4)) - 2);
      end
      default: h.hadron_energy = ENERGY_W'(t / int'($urandom_range(1, 8)));
    endcase
    sel = $urandom_range(0, 5);
    if (sel == 0) h.hit_weight = '0;
    else if (sel == 1) h.hit_weight = 17'd65536;
    else h.hit_weight = WEIGHT_W'($urandom_range(0, 65536));
    h.last_hit = last;
    h.gap = 0;
    h.drain = 1'b0;
    return h;
  endfunction

  task automatic queue_clusters(input int n_items, input bit rush, input bit long_first);
    int target, len;
    bit broken, long_next;
    target = hits_queued + n_items;
    long_next = long_first;
    while (hits_queued < target) begin
      if (rush) len = $urandom_range(1, 4);
      else if (long_next || $urandom_range(0, 24) == 0)
        len = $urandom_range(MAX_HITS - 4, MAX_HITS + 16);
      else len = $urandom_range(1, 12);
      long_next = 1'b0;
      if ($urandom_range(0, 4) == 0) quiet_tx = !quiet_tx;
      broken = !rush && ($urandom_range(0, 19) == 0);
      for (int i = 0; i < len; i++) push_hit(random_hit(i == len - 1, broken), rush);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (!(hits_accepted == hits_queued && clusters_sent == clusters_seen));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HAD_THR: had_thr_reg = val;
      CFG_INT_THR: int_thr_reg = val;
      CFG_SPLIT:   split_reg = val;
      default: ;
    endcase
  endtask

  initial begin
    hit_beat_t pause;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    add_hit(1'b1, KIND_PHOTON_HADRON, 5000, 31, 65536, 1'b0);
    add_hit(1'b1, KIND_BG_PHOTON, 6000, 31, 1, 1'b0);
    add_hit(1'b1, KIND_PHOTON_HADRON, 6000, 30, 7, 1'b0);
    add_hit(1'b1, KIND_POOR_CHI2, 100, 100, 100, 1'b1);
    add_hit(1'b0, KIND_PHOTON_HADRON, 131071, 131071, 65536, 1'b0);
    add_hit(1'b1, KIND_DIODE, -131072, -131072, 65536, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, 0, 100, 100, 1'b1);
    add_hit(1'b1, KIND_BG_PHOTON, 20000, 5000, 0, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, 131071, -131072, 65536, 1'b0);
    add_hit(1'b1, KIND_BG_PHOTON, -131072, 131071, 65536, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, 1, 131071, 300, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, 1, -131072, 300, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, -6000, 29, 5, 1'b1);
    add_hit(1'b1, KIND_PHOTON_HADRON, 6000, -5, 65535, 1'b0);
    add_hit(1'b1, KIND_BG_PHOTON, 65535, 131071, 65536, 1'b1);
    queue_clusters(300, 1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_HAD_THR, CFG_W'($urandom_range(0, 500)));
    write_reg(CFG_INT_THR, CFG_W'($urandom_range(0, 65535)));
    write_reg(CFG_SPLIT, CFG_W'($urandom_range(0, 65535)));
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
    queue_clusters(150, 1'b0, 1'b0);
    pause.drain = 1'b1;
    hit_queue.push_back(pause);
    queue_clusters(150, 1'b0, 1'b0);
    wait_idle();

    write_reg(CFG_HAD_THR, '0);
    write_reg(CFG_INT_THR, '0);
    write_reg(CFG_SPLIT, '0);
    cfg_valid <= 1'b0;
    @(negedge clk);
    add_hit(1'b1, KIND_PHOTON_HADRON, 0, 1, 10, 1'b0);
    add_hit(1'b1, KIND_PHOTON_HADRON, 0, 0, 10, 1'b0);
    add_hit(1'b1, KIND_BG_PHOTON, 0, -1, 10, 1'b1);
    queue_clusters(300, 1'b0, 1'b0);
    wait_idle();

    write_reg(CFG_HAD_THR, '1);
    write_reg(CFG_INT_THR, '1);
    write_reg(CFG_SPLIT, '1);
    cfg_valid <= 1'b0;
    @(negedge clk);
    queue_clusters(300, 1'b0, 1'b0);
    wait_idle();

    write_reg(CFG_UNUSED, CFG_W'($urandom));
    write_reg(CFG_HAD_THR, HAD_THR_RESET);
    write_reg(CFG_INT_THR, INT_THR_RESET);
    write_reg(CFG_SPLIT, SPLIT_RESET);
    cfg_valid <= 1'b0;
    @(negedge clk);
    hold_armed = 1'b1;
    queue_clusters(60, 1'b1, 1'b0);
    queue_clusters(270, 1'b0, 1'b0);
    wait_idle();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("cluster_hadron_fraction_accumulator_unit_test passed");
    end else begin
      $display("cluster_hadron_fraction_accumulator_unit_test failed");
    end
    $finish;
  end

endmodule
